>>> hdl/mom_pkg.sv
`default_nettype none
package mom_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int NUM_FRAMES   = 7;
   localparam int FRAME_ROWS   = 7;
   localparam int TAB_CH       = 8;
   localparam int NUM_AXES     = 4;

   localparam int CH_W    = 3;
   localparam int FR_W    = 3;
   localparam int AX_W    = 2;
   localparam int IN_W    = 16;
   localparam int CMD_W   = IN_W + 1;
   localparam int COEF_W  = 16;
   localparam int PROD_W  = CMD_W + COEF_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int FRAC    = 14;
   localparam int MIX_W   = 20;
   localparam int MAXV_W  = MIX_W - 1;
   localparam int Q_W     = 15;
   localparam int REM_W   = MAXV_W + FRAC + 1;
   localparam int VAL_W   = 16;
   localparam int PULSE_W = 12;
   localparam int IDLE_W  = 15;
   localparam int MULOP_W = PULSE_W + 1;
   localparam int MUL_W   = VAL_W + MULOP_W;
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = 1;

   localparam int ONE_Q14      = 16384;
   localparam int SERVO_CENTER = 1500;
   localparam int SERVO_SPAN   = 500;
   localparam int PULSE_MAX    = 4095;

   typedef enum logic [1:0] {KIND_NONE, KIND_MOTOR, KIND_SERVO} kind_type;

   typedef enum logic [2:0] {
      REG_MIXER, REG_REVERSE, REG_IDLE, REG_SPIN, REG_MIN_PULSE, REG_MAX_PULSE
   } reg_type;

   typedef struct packed {
      logic [FR_W-1:0]    mixer_select;
      logic [3:0]         reverse_mode;
      logic [IDLE_W-1:0]  idle_throttle;
      logic               spin_when_armed;
      logic [PULSE_W-1:0] motor_min_pulse;
      logic [PULSE_W-1:0] motor_max_pulse;
   } cfg_type;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0][MIX_W-1:0] mixed;
      logic [MAXV_W-1:0]                  maxv;
      logic                               armed;
      logic [FR_W-1:0]                    frame;
   } ent_type;

   localparam kind_type KIND_TAB [FRAME_ROWS][TAB_CH] = '{
      '{KIND_MOTOR, KIND_MOTOR, KIND_MOTOR, KIND_MOTOR,
        KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE},
      '{KIND_MOTOR, KIND_MOTOR, KIND_MOTOR, KIND_MOTOR,
        KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE},
      '{KIND_MOTOR, KIND_MOTOR, KIND_MOTOR, KIND_MOTOR,
        KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE},
      '{KIND_MOTOR, KIND_MOTOR, KIND_MOTOR, KIND_SERVO,
        KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE},
      '{KIND_MOTOR, KIND_MOTOR, KIND_MOTOR, KIND_MOTOR,
        KIND_MOTOR, KIND_MOTOR, KIND_NONE, KIND_NONE},
      '{KIND_MOTOR, KIND_MOTOR, KIND_MOTOR, KIND_MOTOR,
        KIND_MOTOR, KIND_MOTOR, KIND_MOTOR, KIND_MOTOR},
      '{KIND_SERVO, KIND_SERVO, KIND_MOTOR, KIND_SERVO,
        KIND_NONE, KIND_NONE, KIND_NONE, KIND_NONE}
   };

   // [frame][thrust, roll, pitch, yaw][channel], Q2.14
   localparam logic signed [COEF_W-1:0] COEF_TAB [FRAME_ROWS][NUM_AXES][TAB_CH] = '{
      '{'{16384, 16384, 16384, 16384, 0, 0, 0, 0},
        '{0, -16384, 16384, 0, 0, 0, 0, 0},
        '{-16384, 0, 0, 16384, 0, 0, 0, 0},
        '{-16384, 16384, 16384, -16384, 0, 0, 0, 0}},
      '{'{16384, 16384, 16384, 16384, 0, 0, 0, 0},
        '{-16384, -16384, 16384, 16384, 0, 0, 0, 0},
        '{-16384, 16384, -16384, 16384, 0, 0, 0, 0},
        '{-16384, 16384, 16384, -16384, 0, 0, 0, 0}},
      '{'{16384, 16384, 16384, 16384, 0, 0, 0, 0},
        '{-17318, -15450, 17318, 15450, 0, 0, 0, 0},
        '{-16466, 16302, -16466, 16302, 0, 0, 0, 0},
        '{-16384, 16384, 16384, -16384, 0, 0, 0, 0}},
      '{'{16384, 16384, 16384, 0, 0, 0, 0, 0},
        '{-16384, 16384, 0, 0, 0, 0, 0, 0},
        '{-10928, -10928, 21840, 0, 0, 0, 0, 0},
        '{0, 0, 0, 16384, 0, 0, 0, 0}},
      '{'{16384, 16384, 16384, 16384, 16384, 16384, 0, 0},
        '{-16384, -16384, 0, 0, 16384, 16384, 0, 0},
        '{10928, 10928, -21840, -21840, 10928, 10928, 0, 0},
        '{-16384, 16384, -16384, 16384, -16384, 16384, 0, 0}},
      '{'{16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384},
        '{-16384, 16384, 16384, -16384, 16384, -16384, -16384, 16384},
        '{16384, 16384, -16384, -16384, 16384, 16384, -16384, -16384},
        '{16384, -16384, 16384, -16384, 16384, -16384, 16384, -16384}},
      '{'{0, 0, 16384, 0, 0, 0, 0, 0},
        '{16384, 0, 0, 0, 0, 0, 0, 0},
        '{0, 16384, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 16384, 0, 0, 0, 0}}
   };

   function automatic logic frame_ok(input logic [FR_W-1:0] f);
      return (int'(f) < NUM_FRAMES) && (int'(f) < FRAME_ROWS);
   endfunction

   function automatic kind_type kind_of(input logic [FR_W-1:0] f,
                                        input logic [CH_W-1:0] ch);
      if (!frame_ok(f) || int'(ch) >= NUM_CHANNELS)
         return KIND_NONE;
      return KIND_TAB[f][ch];
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_of(input logic [FR_W-1:0] f,
                                                        input logic [AX_W-1:0] ax,
                                                        input logic [CH_W-1:0] ch);
      if (!frame_ok(f) || int'(ch) >= NUM_CHANNELS)
         return '0;
      return COEF_TAB[f][ax][ch];
   endfunction

   function automatic logic [CH_W-1:0] last_of(input logic [FR_W-1:0] f);
      logic [CH_W-1:0] r;
      r = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (kind_of(f, CH_W'(i)) != KIND_NONE)
            r = CH_W'(i);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/mom_req_if.sv
`default_nettype none
interface mom_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] thrust;
   logic signed [15:0] roll_cmd;
   logic signed [15:0] pitch_cmd;
   logic signed [15:0] yaw_cmd;
   logic               armed;

   modport source (output valid, thrust, roll_cmd, pitch_cmd, yaw_cmd, armed,
                   input ready);
   modport sink   (input valid, thrust, roll_cmd, pitch_cmd, yaw_cmd, armed,
                   output ready);
endinterface
`default_nettype wire

>>> hdl/mom_rsp_if.sv
`default_nettype none
interface mom_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         channel;
   logic               is_servo;
   logic signed [15:0] output_value;
   logic [11:0]        pulse_us;
   logic               last;

   modport source (output valid, channel, is_servo, output_value, pulse_us, last,
                   input ready);
   modport sink   (input valid, channel, is_servo, output_value, pulse_us, last,
                   output ready);
endinterface
`default_nettype wire

>>> hdl/mom_front.sv
`default_nettype none
module mom_front import mom_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   mom_req_if.sink req,
   input  cfg_type cfg,
   output logic    ent_valid,
   output ent_type ent,
   input  logic    ent_ready
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CH_W-1:0]          cnt_ff, cnt_in;
   logic [CH_W-1:0]          last_ff, last_in;
   logic [FR_W-1:0]          frame_ff, frame_in;
   logic signed [CMD_W-1:0]  cmd_ff [NUM_AXES];
   logic signed [CMD_W-1:0]  cmd_in [NUM_AXES];
   logic                     prod_v_ff, prod_v_in;
   logic                     prod_last_ff, prod_last_in;
   logic [CH_W-1:0]          prod_ch_ff, prod_ch_in;
   logic signed [PROD_W-1:0] prod_ff [NUM_AXES];
   logic signed [PROD_W-1:0] prod_in [NUM_AXES];
   ent_type                  ent_ff, ent_in;
   logic                     accept, push;
   logic signed [ACC_W-1:0]  acc;
   logic signed [MIX_W-1:0]  mixed;
   logic [3:0]               neg;

   assign push      = done_ff && ent_ready;
   assign req.ready = !busy_ff && !prod_v_ff && (!done_ff || push);
   assign accept    = req.valid && req.ready;
   assign ent_valid = done_ff;
   assign ent       = ent_ff;

   always_comb begin
      neg = {cfg.reverse_mode[3:1] & {3{cfg.reverse_mode[0]}}, 1'b0};
      cmd_in[0] = CMD_W'(req.thrust);
      cmd_in[1] = neg[1] ? -CMD_W'(req.roll_cmd)  : CMD_W'(req.roll_cmd);
      cmd_in[2] = neg[2] ? -CMD_W'(req.pitch_cmd) : CMD_W'(req.pitch_cmd);
      cmd_in[3] = neg[3] ? -CMD_W'(req.yaw_cmd)   : CMD_W'(req.yaw_cmd);

      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      frame_in = frame_ff;
      ent_in   = ent_ff;
      done_in  = done_ff && !push;

      prod_v_in    = 1'b0;
      prod_last_in = (cnt_ff == last_ff);
      prod_ch_in   = cnt_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         prod_in[a] = PROD_W'(cmd_ff[a]) * PROD_W'(coef_of(frame_ff, AX_W'(a), cnt_ff));
      end

      // drop items for an unused frame: they give no result
      if (accept && frame_ok(cfg.mixer_select)) begin
         busy_in      = 1'b1;
         cnt_in       = '0;
         frame_in     = cfg.mixer_select;
         last_in      = last_of(cfg.mixer_select);
         ent_in.maxv  = MAXV_W'(ONE_Q14);
         ent_in.armed = req.armed;
         ent_in.frame = cfg.mixer_select;
      end

      if (busy_ff) begin
         prod_v_in = 1'b1;
         if (cnt_ff == last_ff)
            busy_in = 1'b0;
         else
            cnt_in = cnt_ff + 1'b1;
      end

      acc = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2])
          + ACC_W'(prod_ff[3]);
      mixed = acc[FRAC+MIX_W-1:FRAC];
      if (prod_v_ff) begin
         ent_in.mixed[prod_ch_ff] = mixed;
         if (kind_of(frame_ff, prod_ch_ff) != KIND_NONE &&
             mixed > $signed({1'b0, ent_ff.maxv}))
            ent_in.maxv = mixed[MAXV_W-1:0];
         if (prod_last_ff)
            done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         prod_v_ff <= prod_v_in;
      end
      cnt_ff       <= cnt_in;
      last_ff      <= last_in;
      frame_ff     <= frame_in;
      prod_last_ff <= prod_last_in;
      prod_ch_ff   <= prod_ch_in;
      ent_ff       <= ent_in;
      for (int a = 0; a < NUM_AXES; a++) begin
         prod_ff[a] <= prod_in[a];
         if (accept)
            cmd_ff[a] <= cmd_in[a];
      end
   end

endmodule
`default_nettype wire

>>> hdl/mom_queue.sv
`default_nettype none
module mom_queue import mom_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  ent_type push_data,
   output logic    push_ready,
   output logic    pop_valid,
   output ent_type pop_data,
   input  logic    pop
);

   ent_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign push_ready = (cnt_ff != (QPTR_W+1)'(QDEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = slot_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push)
         slot_ff[wr_ff] <= push_data;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_W+1)'(QDEPTH))
      else $error("queue count beyond depth");
   a_push_cnt: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count lost a push");
   a_pop_cnt: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("queue count lost a pop");

endmodule
`default_nettype wire

>>> hdl/mom_back.sv
`default_nettype none
module mom_back import mom_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      ent_valid,
   input  ent_type   ent,
   output logic      ent_pop,
   mom_rsp_if.source rsp
);

   typedef struct packed {
      logic              valid;
      logic [CH_W-1:0]   ch;
      logic              servo;
      logic              last;
      logic              armed;
      logic              div_en;
      logic [MIX_W-1:0]  v;
      logic [REM_W-1:0]  rem;
      logic [MAXV_W-1:0] den;
      logic [Q_W-1:0]    q;
   } stg_type;

   typedef struct packed {
      logic             valid;
      logic [CH_W-1:0]  ch;
      logic             servo;
      logic             last;
      logic [VAL_W-1:0] val;
   } cl_type;

   typedef struct packed {
      logic             valid;
      logic [CH_W-1:0]  ch;
      logic             servo;
      logic             last;
      logic [VAL_W-1:0] val;
      logic [MUL_W-1:0] prod;
   } ml_type;

   logic                     adv;
   logic [CH_W-1:0]          bch_ff, bch_in;
   kind_type                 kind;
   logic signed [MIX_W-1:0]  hv;
   stg_type                  stg_ff [Q_W+1];
   stg_type                  stg_in [Q_W+1];
   cl_type                   cl_ff, cl_in;
   ml_type                   ml_ff, ml_in;
   logic                     out_v_ff;
   logic [CH_W-1:0]          out_ch_ff;
   logic                     out_servo_ff, out_last_ff;
   logic [VAL_W-1:0]         out_val_ff;
   logic [PULSE_W-1:0]       out_pulse_ff, pulse_in;
   logic signed [MIX_W-1:0]  vsel;
   logic signed [MIX_W-1:0]  idle;
   logic signed [MULOP_W-1:0] mulop;
   logic signed [VAL_W-1:0]  pacc;
   logic [REM_W-1:0]         sh;

   // hold every stage while the output item waits
   assign adv     = !out_v_ff || rsp.ready;
   assign kind    = kind_of(ent.frame, bch_ff);
   assign hv      = $signed(ent.mixed[bch_ff]);
   assign ent_pop = ent_valid && adv && (bch_ff == last_of(ent.frame));

   always_comb begin
      bch_in = bch_ff;
      if (ent_valid && adv)
         bch_in = ent_pop ? '0 : bch_ff + 1'b1;

      stg_in[0].valid  = ent_valid && (kind != KIND_NONE);
      stg_in[0].ch     = bch_ff;
      stg_in[0].servo  = (kind == KIND_SERVO);
      stg_in[0].last   = (bch_ff == last_of(ent.frame));
      stg_in[0].armed  = ent.armed;
      stg_in[0].den    = ent.maxv;
      stg_in[0].q      = '0;
      stg_in[0].rem    = REM_W'(hv[MAXV_W-1:0]) << FRAC;
      stg_in[0].v      = hv;
      stg_in[0].div_en = 1'b0;
      if (kind == KIND_MOTOR && ent.maxv > MAXV_W'(ONE_Q14)) begin
         // scaled non-positive motors end up at zero or idle either way
         if (hv > 0)
            stg_in[0].div_en = 1'b1;
         else
            stg_in[0].v = '0;
      end

      // one quotient bit per stage, most significant first
      for (int k = 0; k < Q_W; k++) begin
         stg_in[k+1] = stg_ff[k];
         sh = REM_W'(stg_ff[k].den) << (Q_W - 1 - k);
         if (stg_ff[k].div_en && stg_ff[k].rem >= sh) begin
            stg_in[k+1].rem = stg_ff[k].rem - sh;
            stg_in[k+1].q[Q_W-1-k] = 1'b1;
         end
      end

      vsel = stg_ff[Q_W].div_en ? $signed(MIX_W'(stg_ff[Q_W].q)) : $signed(stg_ff[Q_W].v);
      idle = (cfg.idle_throttle > IDLE_W'(ONE_Q14)) ? MIX_W'(ONE_Q14)
                                                    : $signed(MIX_W'(cfg.idle_throttle));
      cl_in.valid = stg_ff[Q_W].valid;
      cl_in.ch    = stg_ff[Q_W].ch;
      cl_in.servo = stg_ff[Q_W].servo;
      cl_in.last  = stg_ff[Q_W].last;
      if (stg_ff[Q_W].servo) begin
         if (vsel > MIX_W'(ONE_Q14))
            cl_in.val = VAL_W'(ONE_Q14);
         else if (vsel < -MIX_W'(ONE_Q14))
            cl_in.val = -VAL_W'(ONE_Q14);
         else
            cl_in.val = vsel[VAL_W-1:0];
      end else if (!stg_ff[Q_W].armed) begin
         cl_in.val = '0;
      end else if (vsel > MIX_W'(ONE_Q14)) begin
         cl_in.val = VAL_W'(ONE_Q14);
      end else if (cfg.spin_when_armed && vsel < idle) begin
         cl_in.val = idle[VAL_W-1:0];
      end else if (vsel < 0) begin
         cl_in.val = '0;
      end else begin
         cl_in.val = vsel[VAL_W-1:0];
      end

      mulop = cl_ff.servo ? MULOP_W'(SERVO_SPAN)
                          : $signed({1'b0, cfg.motor_max_pulse})
                            - $signed({1'b0, cfg.motor_min_pulse});
      ml_in.valid = cl_ff.valid;
      ml_in.ch    = cl_ff.ch;
      ml_in.servo = cl_ff.servo;
      ml_in.last  = cl_ff.last;
      ml_in.val   = cl_ff.val;
      ml_in.prod  = MUL_W'($signed(cl_ff.val)) * MUL_W'(mulop);

      pacc = (ml_ff.servo ? VAL_W'(SERVO_CENTER) : VAL_W'(cfg.motor_min_pulse))
           + VAL_W'($signed(ml_ff.prod) >>> FRAC);
      if (pacc < 0)
         pulse_in = '0;
      else if (pacc > VAL_W'(PULSE_MAX))
         pulse_in = PULSE_W'(PULSE_MAX);
      else
         pulse_in = pacc[PULSE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= Q_W; k++)
            stg_ff[k].valid <= 1'b0;
         cl_ff.valid <= 1'b0;
         ml_ff.valid <= 1'b0;
         out_v_ff    <= 1'b0;
         bch_ff      <= '0;
      end else begin
         bch_ff <= bch_in;
         if (adv) begin
            for (int k = 0; k <= Q_W; k++)
               stg_ff[k] <= stg_in[k];
            cl_ff        <= cl_in;
            ml_ff        <= ml_in;
            out_v_ff     <= ml_ff.valid;
            out_ch_ff    <= ml_ff.ch;
            out_servo_ff <= ml_ff.servo;
            out_last_ff  <= ml_ff.last;
            out_val_ff   <= ml_ff.val;
            out_pulse_ff <= pulse_in;
         end
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.channel      = out_ch_ff;
   assign rsp.is_servo     = out_servo_ff;
   assign rsp.output_value = out_val_ff;
   assign rsp.pulse_us     = out_pulse_ff;
   assign rsp.last         = out_last_ff;

   a_motor_range: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_servo_ff) |->
         ($signed(out_val_ff) >= 0 && $signed(out_val_ff) <= ONE_Q14))
      else $error("motor value out of range");
   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_servo_ff) |->
         ($signed(out_val_ff) >= -ONE_Q14 && $signed(out_val_ff) <= ONE_Q14))
      else $error("servo value out of range");
   a_servo_pulse: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_servo_ff) |->
         (out_pulse_ff >= PULSE_W'(SERVO_CENTER - SERVO_SPAN) &&
          out_pulse_ff <= PULSE_W'(SERVO_CENTER + SERVO_SPAN)))
      else $error("servo pulse outside its span");

endmodule
`default_nettype wire

>>> hdl/multirotor_output_mixer.sv
// Multirotor / fixed-wing output mixer.
// req_ch takes one thrust/roll/pitch/yaw command with the armed flag; rsp_ch
// gives one item per active channel of the selected frame, in channel order,
// with last set on the final one. An unused frame selector gives no item.
// The csr_ APB port holds the frame select, axis reversal, idle throttle,
// spin mode and motor pulse limits; write it only while the block is idle.
// Throughput: the front end mixes one channel a cycle and takes the next item
// only once the previous result is complete and handed to the queue; the back
// end issues one channel a cycle unless rsp_ch stalls, and keeps up.
// A two-entry queue between them lets the front mix the next command while the
// back still emits the last one.
// Between accept and the first result an item passes the front mix, the queue,
// the 15-stage motor scaling divider and the clamp, pulse and output stages.
// When rsp_ch stalls, the whole back pipeline holds; the queue then fills and
// req_ch.ready drops. Reset empties the queue and pipeline and loads the
// register defaults (pulse 1000 to 2000 us, everything else zero).
`default_nettype none
module multirotor_output_mixer import mom_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mom_req_if.sink     req_ch,
   mom_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg_ff, cfg_in;
   logic    wr;
   ent_type f_ent, q_ent;
   logic    f_valid, f_ready, q_valid, q_pop;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (reg_type'(csr_paddr[4:2]))
            REG_MIXER:     cfg_in.mixer_select    = csr_pwdata[FR_W-1:0];
            REG_REVERSE:   cfg_in.reverse_mode    = csr_pwdata[3:0];
            REG_IDLE:      cfg_in.idle_throttle   = csr_pwdata[IDLE_W-1:0];
            REG_SPIN:      cfg_in.spin_when_armed = csr_pwdata[0];
            REG_MIN_PULSE: cfg_in.motor_min_pulse = csr_pwdata[PULSE_W-1:0];
            REG_MAX_PULSE: cfg_in.motor_max_pulse = csr_pwdata[PULSE_W-1:0];
            default: ;
         endcase
      end
      case (reg_type'(csr_paddr[4:2]))
         REG_MIXER:     csr_prdata = 32'(cfg_ff.mixer_select);
         REG_REVERSE:   csr_prdata = 32'(cfg_ff.reverse_mode);
         REG_IDLE:      csr_prdata = 32'(cfg_ff.idle_throttle);
         REG_SPIN:      csr_prdata = 32'(cfg_ff.spin_when_armed);
         REG_MIN_PULSE: csr_prdata = 32'(cfg_ff.motor_min_pulse);
         REG_MAX_PULSE: csr_prdata = 32'(cfg_ff.motor_max_pulse);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {FR_W'(0), 4'd0, IDLE_W'(0), 1'b0,
                    PULSE_W'(1000), PULSE_W'(2000)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mom_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cfg       (cfg_ff),
      .ent_valid (f_valid),
      .ent       (f_ent),
      .ent_ready (f_ready)
   );

   mom_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_valid),
      .push_data  (f_ent),
      .push_ready (f_ready),
      .pop_valid  (q_valid),
      .pop_data   (q_ent),
      .pop        (q_pop)
   );

   mom_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ent_valid (q_valid),
      .ent       (q_ent),
      .ent_pop   (q_pop),
      .rsp       (rsp_ch)
   );

endmodule
`default_nettype wire
